// File: rtl/core/toroidal_four_state_automaton_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the toroidal four-state automaton
// Concurrent checks on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_FOUR_STATE_AUTOMATON_DEFINES_SVH
`define TOROIDAL_FOUR_STATE_AUTOMATON_DEFINES_SVH
`ifndef ASSERT_OFF
`define TFSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define TFSA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TFSA_ASSERT(lbl, prop)
`define TFSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/tfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsa_pkg
// Types and constants shared by the automaton core and its channels.
// ----------------------------------------------------------------------------
package tfsa_pkg;
	localparam int MAX_SIDE = 64;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int ADDR_W   = 2 * SIDE_W;
	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int CELL_W   = 2;
	localparam int SIZE_W   = 7;
	localparam int GEN_W    = 16;
	localparam int CFG_W    = 16;
	localparam int MIN_SIDE = 5;

	localparam logic [CELL_W-1:0] ADULT = 2'd3;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	typedef enum logic {
		REG_GRID_SIZE = 1'b0,
		REG_GEN_COUNT = 1'b1
	} reg_idx_t;
endpackage

// File: rtl/core/tfsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsa_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tfsa_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [tfsa_pkg::SIDE_W-1:0] row;
	logic [tfsa_pkg::SIDE_W-1:0] column;
	logic [tfsa_pkg::CELL_W-1:0] cell_value;

	modport source (output valid, mode, row, column, cell_value, input ready);
	modport sink (input valid, mode, row, column, cell_value, output ready);
endinterface

interface tfsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tfsa_pkg::CELL_W-1:0] read_value;
	logic                        done_res;

	modport source (output valid, read_value, done_res, input ready);
	modport sink (input valid, read_value, done_res, output ready);
endinterface

// File: rtl/core/toroidal_four_state_automaton.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_four_state_automaton
// Toroidal 2-bit cell grid with a 5x5 adult-count rule, held in block RAM.
// ----------------------------------------------------------------------------
// Write item: result registered in the cycle after accept. Read item: result
// registered from ST_READ. Run item: per generation, 25 window reads of the one
// grid read port per cell plus one update, then a pass to copy the new grid back.
// One item at a time; the next item is taken once its result register frees.
// Reset: clearing pass over all 4096 grid entries, no item taken meanwhile.
`include "toroidal_four_state_automaton_defines.svh"

module toroidal_four_state_automaton (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [tfsa_pkg::CFG_W-1:0]  cfg_data,
	tfsa_req_if.sink                    req,
	tfsa_rsp_if.source                  rsp
);
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CALC  = 5'b01000,
		ST_COPY  = 5'b10000
	} state_t;

	localparam int AW = tfsa_pkg::ADDR_W;
	localparam int SW = tfsa_pkg::SIDE_W;

	state_t state_q;
	logic [tfsa_pkg::SIZE_W-1:0] gsize_q;
	logic [tfsa_pkg::GEN_W-1:0]  gcount_q;
	logic [tfsa_pkg::GEN_W-1:0]  gen_q;
	logic [AW-1:0]               clr_q;
	logic [SW-1:0]               r_q, c_q;
	logic [2:0]                  kr_q, kc_q;
	logic                        fin_q;
	logic                        pend_s1, ctr_s1;
	logic [4:0]                  cnt_q;
	logic [tfsa_pkg::CELL_W-1:0] ctr_q;
	logic                        cp_last_q, cp_s1;
	logic [AW-1:0]               cp_addr_s1;
	logic                        inside_q;
	logic                        ov_q, dn_q;
	logic [tfsa_pkg::CELL_W-1:0] rv_q;

	logic [tfsa_pkg::CELL_W-1:0] cur_mem [tfsa_pkg::DEPTH];
	logic [tfsa_pkg::CELL_W-1:0] nxt_mem [tfsa_pkg::DEPTH];
	logic [tfsa_pkg::CELL_W-1:0] cur_rd_q, nxt_rd_q;

	logic [6:0]                  n;
	logic [6:0]                  n_m1;
	logic                        req_fire, in_grid;
	logic                        cur_we;
	logic [AW-1:0]               cur_wa, cur_ra, req_addr, cell_addr;
	logic [tfsa_pkg::CELL_W-1:0] cur_wd;
	logic                        nxt_we;
	logic [tfsa_pkg::CELL_W-1:0] nxt_wd;
	logic [SW-1:0]               win_r, win_c;
	logic [4:0]                  cnt_fin;
	logic                        last_col, last_row, gen_last;
	tfsa_pkg::mode_t             mode;

	function automatic logic [SW-1:0] wrap(input logic [6:0] t, input logic [6:0] side);
		logic [7:0] w;
		if (t < 7'd2) w = {1'b0, t} + {1'b0, side} - 8'd2;
		else          w = {1'b0, t} - 8'd2;
		if (w >= {1'b0, side}) w = w - {1'b0, side};
		return w[SW-1:0];
	endfunction

	function automatic logic [tfsa_pkg::CELL_W-1:0] rule(
		input logic [tfsa_pkg::CELL_W-1:0] cur_cell, input logic [4:0] cnt);
		logic [tfsa_pkg::CELL_W-1:0] nx;
		case (cur_cell)
			2'd0:    nx = (cnt >= 5'd3 && cnt <= 5'd5) ? 2'd1 : 2'd0;
			2'd1:    nx = 2'd2;
			2'd2:    nx = 2'd3;
			default: nx = (cnt >= 5'd4 && cnt <= 5'd9) ? tfsa_pkg::ADULT : 2'd0;
		endcase
		return nx;
	endfunction

	assign n = (gsize_q < 7'(tfsa_pkg::MIN_SIDE)) ? 7'(tfsa_pkg::MIN_SIDE) :
		(gsize_q > 7'(tfsa_pkg::MAX_SIDE)) ? 7'(tfsa_pkg::MAX_SIDE) : gsize_q;
	assign n_m1 = n - 7'd1;

	assign mode      = tfsa_pkg::mode_t'(req.mode);
	assign req.ready = (state_q == ST_IDLE) && (!ov_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign in_grid   = ({1'b0, req.row} < n) && ({1'b0, req.column} < n);
	assign req_addr  = {req.row, req.column};
	assign cell_addr = {r_q, c_q};

	assign win_r   = wrap(7'(r_q) + 7'(kr_q), n);
	assign win_c   = wrap(7'(c_q) + 7'(kc_q), n);
	assign cur_ra  = (state_q == ST_CALC) ? {win_r, win_c} : req_addr;
	assign cnt_fin = cnt_q + 5'((pend_s1 && !ctr_s1 && cur_rd_q == tfsa_pkg::ADULT) ? 1 : 0);

	assign last_col = ({1'b0, c_q} == n_m1);
	assign last_row = ({1'b0, r_q} == n_m1);
	assign gen_last = (gen_q == gcount_q - 16'd1);

	always_comb begin
		cur_we = 1'b0;
		cur_wa = req_addr;
		cur_wd = req.cell_value;
		case (state_q)
			ST_CLEAR: begin
				cur_we = 1'b1;
				cur_wa = clr_q;
				cur_wd = '0;
			end
			ST_COPY: begin
				cur_we = cp_s1;
				cur_wa = cp_addr_s1;
				cur_wd = nxt_rd_q;
			end
			ST_IDLE: begin
				cur_we = req_fire && mode == tfsa_pkg::MODE_WRITE && in_grid;
			end
			default: cur_we = 1'b0;
		endcase
	end

	assign nxt_we = (state_q == ST_CALC) && fin_q;
	assign nxt_wd = rule(ctr_q, cnt_fin);

	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		cur_rd_q <= cur_mem[cur_ra];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[cell_addr] <= nxt_wd;
		nxt_rd_q <= nxt_mem[cell_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q  <= 7'(tfsa_pkg::MAX_SIDE);
			gcount_q <= 16'd1;
		end else if (cfg_we) begin
			case (tfsa_pkg::reg_idx_t'(cfg_idx))
				tfsa_pkg::REG_GRID_SIZE: gsize_q  <= cfg_data[tfsa_pkg::SIZE_W-1:0];
				tfsa_pkg::REG_GEN_COUNT: gcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			gen_q      <= '0;
			r_q        <= '0;
			c_q        <= '0;
			kr_q       <= '0;
			kc_q       <= '0;
			fin_q      <= 1'b0;
			pend_s1    <= 1'b0;
			ctr_s1     <= 1'b0;
			cnt_q      <= '0;
			ctr_q      <= '0;
			cp_last_q  <= 1'b0;
			cp_s1      <= 1'b0;
			cp_addr_s1 <= '0;
			inside_q   <= 1'b0;
			ov_q       <= 1'b0;
			dn_q       <= 1'b0;
			rv_q       <= '0;
		end else begin
			if (ov_q && rsp.ready) ov_q <= 1'b0;
			pend_s1 <= 1'b0;
			cp_s1   <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_fire) begin
						inside_q <= in_grid;
						case (mode)
							tfsa_pkg::MODE_WRITE: begin
								ov_q <= 1'b1;
								rv_q <= '0;
								dn_q <= 1'b1;
							end
							tfsa_pkg::MODE_READ: state_q <= ST_READ;
							tfsa_pkg::MODE_RUN: begin
								if (gcount_q == '0) begin
									ov_q <= 1'b1;
									rv_q <= '0;
									dn_q <= 1'b1;
								end else begin
									state_q <= ST_CALC;
									gen_q   <= '0;
									r_q     <= '0;
									c_q     <= '0;
									kr_q    <= '0;
									kc_q    <= '0;
									fin_q   <= 1'b0;
									cnt_q   <= '0;
								end
							end
							default: begin
								ov_q <= 1'b1;
								rv_q <= '0;
								dn_q <= 1'b0;
							end
						endcase
					end
				end
				ST_READ: begin
					ov_q    <= 1'b1;
					rv_q    <= inside_q ? cur_rd_q : '0;
					dn_q    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CALC: begin
					if (!fin_q) begin
						pend_s1 <= 1'b1;
						ctr_s1  <= (kr_q == 3'd2) && (kc_q == 3'd2);
						if (kc_q == 3'd4) begin
							kc_q <= '0;
							kr_q <= kr_q + 3'd1;
						end else begin
							kc_q <= kc_q + 3'd1;
						end
						if (kr_q == 3'd4 && kc_q == 3'd4) fin_q <= 1'b1;
						if (pend_s1) begin
							if (ctr_s1) ctr_q <= cur_rd_q;
							else cnt_q <= cnt_fin;
						end
					end else begin
						fin_q <= 1'b0;
						kr_q  <= '0;
						kc_q  <= '0;
						cnt_q <= '0;
						if (last_col) begin
							c_q <= '0;
							if (last_row) begin
								r_q       <= '0;
								cp_last_q <= 1'b0;
								state_q   <= ST_COPY;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				ST_COPY: begin
					if (!cp_last_q) begin
						cp_s1      <= 1'b1;
						cp_addr_s1 <= cell_addr;
						if (last_col) begin
							c_q <= '0;
							if (last_row) begin
								r_q       <= '0;
								cp_last_q <= 1'b1;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						cp_last_q <= 1'b0;
						if (gen_last) begin
							ov_q    <= 1'b1;
							rv_q    <= '0;
							dn_q    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							gen_q   <= gen_q + 16'd1;
							state_q <= ST_CALC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.read_value = rv_q;
	assign rsp.done_res   = dn_q;

	`TFSA_ASSERT(a_ready_idle, req.ready |-> state_q == ST_IDLE)
	`TFSA_ASSERT(a_read_result, state_q == ST_READ |=> ov_q && dn_q)
	`TFSA_ASSERT(a_copy_only, cp_s1 |-> state_q == ST_COPY)
	`TFSA_ASSERT(a_window_end, fin_q |-> kr_q == 3'd5 && kc_q == 3'd0 && state_q == ST_CALC)
	`TFSA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp.valid)
endmodule
